FILE: sv/pcb_pkg.sv
// Package for the packed 4bpp clipped blit: register indexes, widths, queue entry type.
// No dependencies.
package pcb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int COORD_W    = 12;
  localparam int ADDR_W     = 16;
  localparam int NIBBLE_W   = 4;
  localparam int Q_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  localparam logic [COORD_W-1:0] IMAGE_SIZE_RESET = 12'd256;

  // one byte's visible work: first visible pixel position and colours
  typedef struct packed {
    logic [COORD_W-1:0]  x_first;
    logic [COORD_W-1:0]  y;
    logic                two;
    logic [NIBBLE_W-1:0] colour_a;
    logic [NIBBLE_W-1:0] colour_b;
  } entry_t;

endpackage

FILE: sv/pcb_if.sv
// Valid/ready channel interfaces for source bytes and framebuffer writes.
// No dependencies.
interface pcb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface pcb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_address;
  logic [3:0]  pixel_colour;
  logic        last_of_run;
  modport source (output valid, output pixel_address, output pixel_colour,
                  output last_of_run, input ready);
  modport sink (input valid, input pixel_address, input pixel_colour,
                input last_of_run, output ready);
endinterface

FILE: sv/pcb_front.sv
// Front: config registers, image counters, clipping; pushes visible work to the queue.
// Depends on pcb_pkg and pcb_in_if.
module pcb_front #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data,
  pcb_in_if.sink                        in_ch,
  input  logic                          q_full,
  output logic                          push,
  output pcb_pkg::entry_t               entry
);
  import pcb_pkg::*;

  localparam logic signed [13:0] SW14 = 14'(SCREEN_WIDTH);
  localparam logic signed [13:0] SH14 = 14'(SCREEN_HEIGHT);

  logic signed [12:0] origin_x, origin_y;
  logic [COORD_W-1:0] image_width, image_height;
  logic [COORD_W-1:0] col, row;

  logic               accept, empty_img, vis0, vis1, row_ok, wrap_col;
  logic signed [13:0] sx, sx1, sy;
  logic [12:0]        col_plus1, col_plus2, row_plus1;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign empty_img   = (image_width == '0) || (image_height == '0);

  assign sx  = {origin_x[12], origin_x} + $signed({2'b00, col});
  assign sx1 = sx + 14'sd1;
  assign sy  = {origin_y[12], origin_y} + $signed({2'b00, row});

  assign col_plus1 = {1'b0, col} + 13'd1;
  assign col_plus2 = {1'b0, col} + 13'd2;
  assign row_plus1 = {1'b0, row} + 13'd1;
  assign wrap_col  = col_plus2 >= {1'b0, image_width};

  assign row_ok = (sy >= 14'sd0) && (sy < SH14);
  assign vis0   = row_ok && (sx >= 14'sd0) && (sx < SW14);
  assign vis1   = row_ok && (col_plus1 < {1'b0, image_width}) &&
                  (sx1 >= 14'sd0) && (sx1 < SW14);

  assign push           = accept && !empty_img && (vis0 || vis1);
  assign entry.x_first  = vis0 ? sx[COORD_W-1:0] : sx1[COORD_W-1:0];
  assign entry.y        = sy[COORD_W-1:0];
  assign entry.two      = vis0 && vis1;
  assign entry.colour_a = vis0 ? in_ch.source_byte[3:0] : in_ch.source_byte[7:4];
  assign entry.colour_b = in_ch.source_byte[7:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      image_width  <= IMAGE_SIZE_RESET;
      image_height <= IMAGE_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X:     origin_x     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y     <= cfg_data;
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[COORD_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (empty_img) begin
        col <= '0;
        row <= '0;
      end else if (wrap_col) begin
        col <= '0;
        row <= (row_plus1 >= {1'b0, image_height}) ? '0 : row_plus1[COORD_W-1:0];
      end else begin
        col <= col_plus2[COORD_W-1:0];
      end
    end
  end

endmodule

FILE: sv/pcb_queue.sv
// Small register FIFO of clipped work entries between front and back.
// Depends on pcb_pkg.
module pcb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pcb_pkg::entry_t wr_entry,
  input  logic            pop,
  output pcb_pkg::entry_t head,
  output logic            empty,
  output logic            full
);
  import pcb_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  entry_t           mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(Q_DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(Q_DEPTH)) else $error("queue count exceeds depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("pop from empty queue");

endmodule

FILE: sv/pcb_back.sv
// Back: drains the queue into an output register, one write per cycle unless stalled.
// Depends on pcb_pkg and pcb_out_if.
module pcb_back #(
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  pcb_pkg::entry_t head,
  input  logic            q_empty,
  output logic            pop,
  pcb_out_if.source       out_ch
);
  import pcb_pkg::*;

  localparam logic [31:0] SH32 = 32'(SCREEN_HEIGHT);

  logic               phase, load, emit, last;
  logic [COORD_W-1:0] x;
  logic [31:0]        addr;

  assign load = !out_ch.valid || out_ch.ready;
  assign emit = load && !q_empty;
  assign last = !head.two || phase;
  assign pop  = emit && last;
  assign x    = head.x_first + COORD_W'(phase);
  assign addr = 32'(x) * SH32 + 32'(head.y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      phase        <= 1'b0;
    end else begin
      if (load) out_ch.valid <= !q_empty;
      if (emit) phase <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.pixel_address <= addr[ADDR_W-1:0];
      out_ch.pixel_colour  <= phase ? head.colour_b : head.colour_a;
      out_ch.last_of_run   <= last;
    end
  end

  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!q_empty && head.two)) else $error("second pixel without entry");
  a_second_last: assert property (@(posedge clk) disable iff (rst)
    (emit && phase) |=> out_ch.last_of_run) else $error("second pixel not last");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |-> (phase || !head.two)) else $error("entry popped early");

endmodule

FILE: sv/packed_4bpp_clipped_blit.sv
// A source byte's writes pass through the queue and then the output register.
// Throughput: one byte per cycle into a 4-entry queue while it is not full, one write
// per cycle out while the sink is ready; the single output write port sets the pace.
// Reset: offsets 0, sizes 256, counters zero, queue and output register empty.
// Depends on pcb_pkg, pcb_if, pcb_front, pcb_queue, pcb_back.
module packed_4bpp_clipped_blit #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_data,
  pcb_in_if.sink                        in_ch,
  pcb_out_if.source                     out_ch
);
  import pcb_pkg::*;

  entry_t wr_entry, head;
  logic   push, pop, q_empty, q_full;

  pcb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .entry     (wr_entry)
  );

  pcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pcb_back #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for packed_4bpp_clipped_blit: directed clip cases, then random images.
// Predicts every framebuffer write and compares each accepted one in order.
// Depends on pcb_pkg, pcb_if and the packed_4bpp_clipped_blit RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcb_pkg::*;

  localparam int SCREEN_W     = 256;
  localparam int SCREEN_H     = 256;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1480;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [NIBBLE_W-1:0] colour;
    logic                last;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcb_in_if  in_ch ();
  pcb_out_if out_ch ();

  packed_4bpp_clipped_blit #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor copy of registers and counters
  logic signed [CFG_DATA_W-1:0] org_x, org_y;
  logic [COORD_W-1:0] img_w, img_h;
  logic [COORD_W-1:0] col_pos, row_pos;

  fb_write_t pending_writes[$];
  fb_write_t head_write;

  bit idle_on;
  int errors;
  int cycle_count;
  int bytes_drawn;
  int bytes_ignored;
  int writes_seen;
  int settings_count;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= idle_on ? ($urandom_range(99) >= 37) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write: pixel_address %0d pixel_colour %0d last_of_run %0d",
               out_ch.pixel_address, out_ch.pixel_colour, out_ch.last_of_run);
        errors++;
      end else begin
        head_write = pending_writes.pop_front();
        writes_seen++;
        if (out_ch.pixel_address !== head_write.address) begin
          $error("pixel_address: expected %0d, got %0d", head_write.address,
                 out_ch.pixel_address);
          errors++;
        end
        if (out_ch.pixel_colour !== head_write.colour) begin
          $error("pixel_colour: expected %0d, got %0d", head_write.colour,
                 out_ch.pixel_colour);
          errors++;
        end
        if (out_ch.last_of_run !== head_write.last) begin
          $error("last_of_run: expected %0d, got %0d", head_write.last,
                 out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  function automatic bit on_screen(input int sx, input int sy);
    return sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
  endfunction

  function automatic logic [ADDR_W-1:0] fb_address(input int sx, input int sy);
    return ADDR_W'(sx * SCREEN_H + sy);
  endfunction

  function automatic void blit_predict(input logic [7:0] b);
    fb_write_t wr [2];
    int n;
    int sx, sy;
    int next_col;
    n = 0;
    if (img_w == 0 || img_h == 0) begin
      col_pos = '0;
      row_pos = '0;
      bytes_ignored++;
      return;
    end
    bytes_drawn++;
    sy = int'(org_y) + int'(row_pos);
    sx = int'(org_x) + int'(col_pos);
    if (on_screen(sx, sy)) begin
      wr[n] = '{address: fb_address(sx, sy), colour: b[3:0], last: 1'b0};
      n++;
    end
    if (int'(col_pos) + 1 < int'(img_w) && on_screen(sx + 1, sy)) begin
      wr[n] = '{address: fb_address(sx + 1, sy), colour: b[7:4], last: 1'b0};
      n++;
    end
    if (n > 0) wr[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_writes.push_back(wr[k]);
    next_col = int'(col_pos) + 2;
    if (next_col >= int'(img_w)) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= int'(img_h)) row_pos = '0;
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = COORD_W'(next_col);
    end
  endfunction

  // one source byte request per call; entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.source_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    blit_predict(b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_ORIGIN_X:     org_x = data;
      CFG_ORIGIN_Y:     org_y = data;
      CFG_IMAGE_WIDTH:  img_w = data[COORD_W-1:0];
      CFG_IMAGE_HEIGHT: img_h = data[COORD_W-1:0];
      default: ;
    endcase
    settings_count++;
  endtask

  task automatic configure(input int ox, input int oy, input int w, input int h);
    drain();
    write_reg(CFG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  task automatic test_full_frame();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_empty_image();
    configure(0, 0, 0, 8);
    send_byte(8'hFF);
    send_byte(8'h00);
    configure(0, 0, 4, 0);
    send_byte(8'h5A);
    configure(3, 3, 4, 1);
    send_byte(8'hC3);
    send_byte(8'h0F);
  endtask

  task automatic test_odd_width();
    configure(250, 255, 5, 1);
    send_byte(8'h21);
    send_byte(8'h43);
    send_byte(8'h65);
  endtask

  task automatic test_partial_clip();
    configure(-1, -1, 4, 2);
    send_byte(8'h21);
    send_byte(8'h43);
    send_byte(8'h65);
    send_byte(8'h87);
  endtask

  task automatic test_shrink_mid_image();
    configure(0, 0, 8, 3);
    send_byte(8'h10);
    send_byte(8'h32);
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(4));
    send_byte(8'h54);
    drain();
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(1));
    send_byte(8'h76);
    send_byte(8'h98);
    send_byte(8'hBA);
  endtask

  task automatic test_coordinate_extremes();
    configure(-4096, 4095, 4095, 4095);
    send_byte(8'hA5);
    configure(4095, -4096, 4095, 4095);
    send_byte(8'h5A);
  endtask

  task automatic test_random();
    int phase;
    int start_count;
    int choice;
    int reps;
    int n;
    int ox, oy, w, h;
    logic [CFG_IDX_W-1:0] idx;
    phase = 0;
    start_count = bytes_drawn;
    while (bytes_drawn - start_count < RANDOM_ITEMS) begin
      idle_on = !(phase >= 12 && phase < 20);
      choice = $urandom_range(99);
      if (choice < 75) begin
        // whole images with random content, placed around the screen edges
        w  = $urandom_range(24, 1);
        h  = $urandom_range(10, 1);
        ox = int'($urandom_range(w + 259)) - w - 2;
        oy = int'($urandom_range(h + 259)) - h - 2;
        configure(ox, oy, w, h);
        reps = $urandom_range(3, 1);
        for (int r = 0; r < reps; r++) begin
          do begin
            send_byte(8'($urandom));
          end while (!(col_pos == 0 && row_pos == 0));
          if (phase == 3 || $urandom_range(9) == 0) drain();
        end
      end else if (choice < 88) begin
        // one register rewritten with the counters left where they are
        idx = CFG_IDX_W'($urandom_range(3));
        drain();
        if (idx == CFG_ORIGIN_X || idx == CFG_ORIGIN_Y)
          write_reg(idx, CFG_DATA_W'(int'($urandom_range(290)) - 30));
        else
          write_reg(idx, CFG_DATA_W'($urandom_range(30)));
        n = $urandom_range(10, 1);
        repeat (n) send_byte(8'($urandom));
      end else begin
        ox = int'($urandom_range(8191)) - 4096;
        oy = int'($urandom_range(8191)) - 4096;
        if ($urandom_range(9) == 0) ox = $urandom_range(1) ? 4095 : -4096;
        if ($urandom_range(9) == 0) oy = $urandom_range(1) ? 4095 : -4096;
        choice = $urandom_range(9);
        w = (choice == 0) ? 0 : (choice == 1) ? 4095 : $urandom_range(4095);
        choice = $urandom_range(9);
        h = (choice == 0) ? 0 : (choice == 1) ? 4095 : $urandom_range(4095);
        configure(ox, oy, w, h);
        n = $urandom_range(6, 1);
        repeat (n) send_byte(8'($urandom));
      end
      phase++;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.source_byte = '0;
    idle_on           = 1'b1;
    errors            = 0;
    cycle_count       = 0;
    bytes_drawn       = 0;
    bytes_ignored     = 0;
    writes_seen       = 0;
    settings_count    = 0;
    org_x             = '0;
    org_y             = '0;
    img_w             = IMAGE_SIZE_RESET;
    img_h             = IMAGE_SIZE_RESET;
    col_pos           = '0;
    row_pos           = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_full_frame();
    test_empty_image();
    test_odd_width();
    test_partial_clip();
    test_shrink_mid_image();
    test_coordinate_extremes();
    test_random();
    drain();

    errors += pending_writes.size();
    $display("Sent %0d drawn and %0d ignored source bytes over %0d register writes;",
             bytes_drawn, bytes_ignored, settings_count);
    $display("checked %0d framebuffer writes, clipped, odd-width and resized images included.",
             writes_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
